>>> rtl/scd_pkg.sv
// shared types and constants for the scancode to character decoder
package scd_pkg;

   // character queue geometry
   localparam int FIFO_DEPTH    = 256;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

   // layout tables
   localparam int TABLE_ENTRIES = 128;
   localparam int TABLE_ADDR_W  = $clog2(TABLE_ENTRIES);
   localparam int CHAR_W        = 8;

   // set-1 scancodes with special meaning
   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_LCTRL_MAKE   = 8'h1D;
   localparam logic [7:0] SC_LCTRL_BREAK  = 8'h9D;
   localparam logic [7:0] SC_LALT_MAKE    = 8'h38;
   localparam logic [7:0] SC_LALT_BREAK   = 8'hB8;
   localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
   localparam int         SC_RELEASE_BIT  = 7;

   typedef enum logic [1:0] {
      MODE_SCAN       = 2'd0,
      MODE_WR_NORMAL  = 2'd1,
      MODE_WR_SHIFTED = 2'd2,
      MODE_POP        = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [7:0]                scan_byte;
      logic [TABLE_ADDR_W-1:0]   table_index;
      logic [CHAR_W-1:0]         table_char;
   } req_type;

   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] char_out;
      logic              chars_waiting;
      logic              char_dropped;
      logic              shift_held;
      logic              ctrl_held;
      logic              alt_held;
      logic              caps_on;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic ctrl;
      logic alt;
      logic caps;
   } mods_type;

endpackage

>>> rtl/scd_layout_table.sv
// layout table memory with per-entry valid bits and write-to-read bypass
module scd_layout_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [scd_pkg::TABLE_ADDR_W-1:0]   rd_addr,
   input  logic                               wr_en,
   input  logic [scd_pkg::TABLE_ADDR_W-1:0]   wr_addr,
   input  logic [scd_pkg::CHAR_W-1:0]         wr_data,
   output logic [scd_pkg::CHAR_W-1:0]         rd_data
);

   logic [scd_pkg::CHAR_W-1:0]        mem [scd_pkg::TABLE_ENTRIES];
   logic [scd_pkg::TABLE_ENTRIES-1:0] vld_ff;
   logic [scd_pkg::TABLE_ENTRIES-1:0] vld_in;
   logic [scd_pkg::CHAR_W-1:0]        rd_q_ff;
   logic                              rd_hit_ff;
   logic                              rd_hit_in;
   logic                              bypass;

   // a write and a read of the same entry in one cycle returns the new data
   assign bypass    = wr_en & rd_en & (wr_addr == rd_addr);
   assign rd_hit_in = rd_en ? (bypass | vld_ff[rd_addr]) : rd_hit_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= bypass ? wr_data : mem[rd_addr];
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_hit_ff ? rd_q_ff : '0;

`ifndef NO_ASSERTIONS
   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("table valid bits not cleared by reset");

   a_bypass_data: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en && wr_addr == rd_addr) |=> (rd_data == $past(wr_data)))
      else $error("same-cycle write not forwarded to read");

   a_unwritten_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rd_en && !bypass && !vld_ff[rd_addr]) |=> (rd_data == '0))
      else $error("unwritten table entry read as nonzero");
`endif

endmodule

>>> rtl/scancode_to_char_decoder.sv
// top level of the set-1 scancode to character decoder
//
// req channel: one transaction per item (scancode, normal table write,
// shifted table write or character pop), taken when req_valid is high and
// req_stall is low. rsp channel: exactly one transaction per request, in
// order, with the popped character, queue status, drop flag and the
// modifier state after that request.
// path: an accepted request enters the input stage (table and queue-head
// reads), then the result register, where rsp_stall can hold it.
// throughput: one request per cycle while rsp_stall is low, set by the single commit stage that
// updates modifiers, table entries and queue pointers.
// when rsp_stall is high the result register holds, the input stage fills
// and req_stall rises; nothing is lost or repeated.
// reset: modifiers cleared, both layout tables read as zero (valid bits),
// character queue empty; no clearing pass, a request is taken right after.
// the queue keeps FIFO_DEPTH-1 characters; a decoded character that finds
// it full is discarded and flagged with char_dropped.
module scancode_to_char_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scd_pkg::rsp_type rsp_payload
);

   localparam int PW = scd_pkg::FIFO_PTR_W;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PW'(scd_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // handshake and stage control
   logic             req_accept;
   logic             s1_go;
   logic             s1_commit;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   scd_pkg::req_type s1_req_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   scd_pkg::rsp_type rsp_ff;
   scd_pkg::rsp_type rsp_in;

   // modifier state
   scd_pkg::mods_type mods_ff;
   scd_pkg::mods_type mods_in;

   // table read data for the item in the input stage
   logic [scd_pkg::CHAR_W-1:0] normal_rd;
   logic [scd_pkg::CHAR_W-1:0] shifted_rd;
   logic [scd_pkg::CHAR_W-1:0] looked;
   logic [scd_pkg::CHAR_W-1:0] dec_char;

   // character queue
   logic [scd_pkg::CHAR_W-1:0] fifo_mem [scd_pkg::FIFO_DEPTH];
   logic [scd_pkg::CHAR_W-1:0] head_ff;
   logic [PW-1:0]              rd_ptr_ff;
   logic [PW-1:0]              rd_ptr_in;
   logic [PW-1:0]              wr_ptr_ff;
   logic [PW-1:0]              wr_ptr_in;
   logic                       fifo_empty;
   logic                       fifo_full;
   logic                       push;
   logic                       pop;
   logic                       dropped;
   logic                       push_go;
   logic                       pop_go;
   logic                       wr_normal;
   logic                       wr_shifted;

   // input stage moves on when the result register is free or being taken
   assign s1_go        = ~rsp_valid_ff | ~rsp_stall;
   assign s1_commit    = s1_valid_ff & s1_go;
   assign req_stall    = s1_valid_ff & ~s1_go;
   assign req_accept   = req_valid & ~req_stall;
   assign s1_valid_in  = req_accept | (s1_valid_ff & ~s1_go);
   assign rsp_valid_in = s1_commit | (rsp_valid_ff & rsp_stall);

   assign wr_normal  = s1_commit & (s1_req_ff.mode == scd_pkg::MODE_WR_NORMAL);
   assign wr_shifted = s1_commit & (s1_req_ff.mode == scd_pkg::MODE_WR_SHIFTED);

   // both tables are read at accept; the shift state picks one at commit
   scd_layout_table u_normal (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_payload.scan_byte[scd_pkg::TABLE_ADDR_W-1:0]),
      .wr_en   (wr_normal),
      .wr_addr (s1_req_ff.table_index),
      .wr_data (s1_req_ff.table_char),
      .rd_data (normal_rd)
   );

   scd_layout_table u_shifted (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_payload.scan_byte[scd_pkg::TABLE_ADDR_W-1:0]),
      .wr_en   (wr_shifted),
      .wr_addr (s1_req_ff.table_index),
      .wr_data (s1_req_ff.table_char),
      .rd_data (shifted_rd)
   );

   // caps lock swaps letter case against the shift state
   always_comb begin
      looked   = mods_ff.shift ? shifted_rd : normal_rd;
      dec_char = looked;
      if (mods_ff.caps && !mods_ff.shift && looked >= "a" && looked <= "z") begin
         dec_char = looked - 8'd32;
      end else if (mods_ff.caps && mods_ff.shift && looked >= "A" && looked <= "Z") begin
         dec_char = looked + 8'd32;
      end
   end

   assign fifo_empty = (rd_ptr_ff == wr_ptr_ff);
   assign fifo_full  = (ptr_next(wr_ptr_ff) == rd_ptr_ff);

   // commit stage decode
   always_comb begin
      mods_in = mods_ff;
      push    = 1'b0;
      pop     = 1'b0;
      dropped = 1'b0;
      unique case (s1_req_ff.mode)
         scd_pkg::MODE_SCAN: begin
            unique case (s1_req_ff.scan_byte) inside
               scd_pkg::SC_LSHIFT_MAKE, scd_pkg::SC_RSHIFT_MAKE: begin
                  mods_in.shift = 1'b1;
               end
               scd_pkg::SC_LSHIFT_BREAK, scd_pkg::SC_RSHIFT_BREAK: begin
                  mods_in.shift = 1'b0;
               end
               scd_pkg::SC_LCTRL_MAKE: begin
                  mods_in.ctrl = 1'b1;
               end
               scd_pkg::SC_LCTRL_BREAK: begin
                  mods_in.ctrl = 1'b0;
               end
               scd_pkg::SC_LALT_MAKE: begin
                  mods_in.alt = 1'b1;
               end
               scd_pkg::SC_LALT_BREAK: begin
                  mods_in.alt = 1'b0;
               end
               scd_pkg::SC_CAPS_MAKE: begin
                  mods_in.caps = ~mods_ff.caps;
               end
               default: begin
                  // other releases ignored, zero entries produce nothing
                  if (!s1_req_ff.scan_byte[scd_pkg::SC_RELEASE_BIT] && dec_char != '0) begin
                     if (fifo_full) begin
                        dropped = 1'b1;
                     end else begin
                        push = 1'b1;
                     end
                  end
               end
            endcase
         end
         scd_pkg::MODE_POP: begin
            pop = ~fifo_empty;
         end
         default: begin
            // table writes are done in the table instances
         end
      endcase
   end

   assign push_go   = s1_commit & push;
   assign pop_go    = s1_commit & pop;
   assign rd_ptr_in = pop_go  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
   assign wr_ptr_in = push_go ? ptr_next(wr_ptr_ff) : wr_ptr_ff;

   always_comb begin
      rsp_in.char_valid    = pop;
      rsp_in.char_out      = pop ? head_ff : '0;
      rsp_in.chars_waiting = (rd_ptr_in != wr_ptr_in);
      rsp_in.char_dropped  = dropped;
      rsp_in.shift_held    = mods_in.shift;
      rsp_in.ctrl_held     = mods_in.ctrl;
      rsp_in.alt_held      = mods_in.alt;
      rsp_in.caps_on       = mods_in.caps;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mods_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         if (s1_commit) begin
            mods_ff <= mods_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      if (s1_commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_go) begin
         fifo_mem[wr_ptr_ff] <= dec_char;
      end
   end

   // head of queue is refetched every cycle, with the push forwarded when
   // it lands on the entry about to become the head
   always_ff @(posedge clock) begin
      if (push_go && wr_ptr_ff == rd_ptr_in) begin
         head_ff <= dec_char;
      end else begin
         head_ff <= fifo_mem[rd_ptr_in];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_drop_means_waiting: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.char_dropped) |-> rsp_payload.chars_waiting)
      else $error("character dropped while queue not full");

   a_pop_never_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.char_valid) |-> !rsp_payload.char_dropped)
      else $error("pop transaction flagged a drop");

   a_stall_needs_stage: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with empty input stage");

   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      pop_go |=> (rd_ptr_ff != $past(rd_ptr_ff)))
      else $error("pop did not advance read pointer");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      fifo_full |-> !push_go)
      else $error("push into full queue");
`endif

endmodule

>>> tb/sv/scd_checker.sv
// checker for the scancode decoder: predicts each response and compares it
module scd_checker
   import scd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,
   output int unsigned mismatch_count,
   output int unsigned responses_owed
);

   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam int unsigned REPORT_LIMIT = 10;

   // shadow of the decoder state
   mods_type          held_mods;
   logic [CHAR_W-1:0] normal_layout  [TABLE_ENTRIES];
   logic [CHAR_W-1:0] shifted_layout [TABLE_ENTRIES];
   logic [CHAR_W-1:0] queued_chars   [FIFO_DEPTH];
   int unsigned       head_ptr;
   int unsigned       tail_ptr;

   rsp_type     expected_responses [$];
   int unsigned rsp_seen;

   function automatic int unsigned ring_next(input int unsigned p);
      return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
   endfunction

   // applies one request to the shadow state and returns its response
   function automatic rsp_type decode_request(input req_type item);
      rsp_type           res;
      logic [CHAR_W-1:0] c;
      res = '0;
      case (item.mode)
         MODE_SCAN: begin
            case (item.scan_byte)
               SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   held_mods.shift = 1'b1;
               SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: held_mods.shift = 1'b0;
               SC_LCTRL_MAKE:  held_mods.ctrl = 1'b1;
               SC_LCTRL_BREAK: held_mods.ctrl = 1'b0;
               SC_LALT_MAKE:   held_mods.alt = 1'b1;
               SC_LALT_BREAK:  held_mods.alt = 1'b0;
               SC_CAPS_MAKE:   held_mods.caps = ~held_mods.caps;
               default: begin
                  if (!item.scan_byte[SC_RELEASE_BIT]) begin
                     c = held_mods.shift ? shifted_layout[item.scan_byte[6:0]]
                                         : normal_layout[item.scan_byte[6:0]];
                     if (held_mods.caps && !held_mods.shift &&
                         c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                        c = c - CASE_BIT;
                     end else if (held_mods.caps && held_mods.shift &&
                                  c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                        c = c + CASE_BIT;
                     end
                     if (c != '0) begin
                        if (ring_next(tail_ptr) == head_ptr) begin
                           res.char_dropped = 1'b1;
                        end else begin
                           queued_chars[tail_ptr] = c;
                           tail_ptr = ring_next(tail_ptr);
                        end
                     end
                  end
               end
            endcase
         end
         MODE_WR_NORMAL:  normal_layout[item.table_index] = item.table_char;
         MODE_WR_SHIFTED: shifted_layout[item.table_index] = item.table_char;
         default: begin
            if (head_ptr != tail_ptr) begin
               res.char_valid = 1'b1;
               res.char_out   = queued_chars[head_ptr];
               head_ptr = ring_next(head_ptr);
            end
         end
      endcase
      res.chars_waiting = (head_ptr != tail_ptr);
      res.shift_held    = held_mods.shift;
      res.ctrl_held     = held_mods.ctrl;
      res.alt_held      = held_mods.alt;
      res.caps_on       = held_mods.caps;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [CHAR_W-1:0] want,
                              input logic [CHAR_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("rsp transaction %0d: %s expected %0h got %0h",
                     rsp_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_mods = '0;
         foreach (normal_layout[i]) normal_layout[i] = '0;
         foreach (shifted_layout[i]) shifted_layout[i] = '0;
         head_ptr = 0;
         tail_ptr = 0;
         expected_responses.delete();
         rsp_seen = 0;
         mismatch_count = 0;
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0)
            expected_responses.push_back(decode_request(req_payload));
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("rsp transaction %0d arrived with none expected", rsp_seen);
            end else begin
               want = expected_responses.pop_front();
               check_field("char_valid", CHAR_W'(want.char_valid),
                           CHAR_W'(rsp_payload.char_valid));
               check_field("char_out", want.char_out, rsp_payload.char_out);
               check_field("chars_waiting", CHAR_W'(want.chars_waiting),
                           CHAR_W'(rsp_payload.chars_waiting));
               check_field("char_dropped", CHAR_W'(want.char_dropped),
                           CHAR_W'(rsp_payload.char_dropped));
               check_field("shift_held", CHAR_W'(want.shift_held),
                           CHAR_W'(rsp_payload.shift_held));
               check_field("ctrl_held", CHAR_W'(want.ctrl_held),
                           CHAR_W'(rsp_payload.ctrl_held));
               check_field("alt_held", CHAR_W'(want.alt_held),
                           CHAR_W'(rsp_payload.alt_held));
               check_field("caps_on", CHAR_W'(want.caps_on),
                           CHAR_W'(rsp_payload.caps_on));
            end
            rsp_seen++;
         end
      end
      responses_owed = expected_responses.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// top of the scancode decoder testbench: clock, reset, stimulus and verdict
module tb_top;
   import scd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   int unsigned mismatch_count;
   int unsigned responses_owed;

   // when set, neither side inserts gaps or stalls
   bit steady_flow;

   // every scancode that changes a modifier
   logic [7:0] modifier_codes [9] = '{SC_LSHIFT_MAKE, SC_RSHIFT_MAKE, SC_LSHIFT_BREAK,
                                      SC_RSHIFT_BREAK, SC_LCTRL_MAKE, SC_LCTRL_BREAK,
                                      SC_LALT_MAKE, SC_LALT_BREAK, SC_CAPS_MAKE};

   scancode_to_char_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   scd_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .responses_owed (responses_owed)
   );

   // period of two time units
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // hard stop in case the block hangs
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

   // character mix: letters of both cases, the bytes around the letter
   // ranges, and arbitrary bytes
   function automatic logic [7:0] pick_char();
      logic [7:0] edges [8] = '{8'h61, 8'h7A, 8'h41, 8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B};
      case ($urandom_range(0, 3))
         0:       return 8'(8'h61 + $urandom_range(0, 25));
         1:       return 8'(8'h41 + $urandom_range(0, 25));
         2:       return edges[$urandom_range(0, 7)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one request transaction: optional gap, then hold valid and payload
   // until the block takes it; valid stays high when the next one follows
   task automatic send_item(input req_type item);
      int unsigned gap;
      bit          taken;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0)
         steady_flow = ~steady_flow;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = (req_stall == 1'b0);
         @(negedge clock);
      end
   endtask

   // unused fields carry random bits so every input bit toggles
   task automatic send_scan(input logic [7:0] code);
      req_type item;
      item.mode        = MODE_SCAN;
      item.scan_byte   = code;
      item.table_index = TABLE_ADDR_W'($urandom_range(0, TABLE_ENTRIES - 1));
      item.table_char  = 8'($urandom_range(0, 255));
      send_item(item);
   endtask

   task automatic send_table_write(input mode_type which, input logic [6:0] idx,
                                   input logic [7:0] ch);
      req_type item;
      item.mode        = which;
      item.scan_byte   = 8'($urandom_range(0, 255));
      item.table_index = idx;
      item.table_char  = ch;
      send_item(item);
   endtask

   task automatic send_pop();
      req_type item;
      item.mode        = MODE_POP;
      item.scan_byte   = 8'($urandom_range(0, 255));
      item.table_index = TABLE_ADDR_W'($urandom_range(0, TABLE_ENTRIES - 1));
      item.table_char  = 8'($urandom_range(0, 255));
      send_item(item);
   endtask

   // general mix; pop_pct sets how fast the character queue drains
   task automatic send_random_item(input int unsigned pop_pct);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < pop_pct)
         send_pop();
      else if (pick < pop_pct + 12)
         send_table_write($urandom_range(0, 1) ? MODE_WR_NORMAL : MODE_WR_SHIFTED,
                          7'($urandom_range(0, TABLE_ENTRIES - 1)), pick_char());
      else if (pick < pop_pct + 22)
         send_scan(modifier_codes[$urandom_range(0, 8)]);
      else if (pick < pop_pct + 30)
         send_scan(8'($urandom_range(0, 255)));
      else
         send_scan(8'($urandom_range(0, 127)));
   endtask

   // response side: random stall before each transaction, then wait for it
   initial begin
      int unsigned hold;
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 4);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      steady_flow = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty pop, table extremes, case swapping, modifiers
      send_pop();
      send_table_write(MODE_WR_NORMAL, 7'h1E, 8'h61);
      send_table_write(MODE_WR_SHIFTED, 7'h1E, 8'h41);
      send_table_write(MODE_WR_NORMAL, 7'h02, 8'h31);
      send_table_write(MODE_WR_SHIFTED, 7'h02, 8'h21);
      send_table_write(MODE_WR_NORMAL, 7'h7F, 8'hFF);
      send_table_write(MODE_WR_SHIFTED, 7'h00, 8'hFF);
      send_scan(8'h1E);
      send_scan(8'h03);              // entry still zero, nothing queued
      send_scan(8'h7F);
      send_scan(SC_CAPS_MAKE);
      send_scan(8'h1E);              // caps turns lower case upper
      send_scan(SC_LSHIFT_MAKE);
      send_scan(8'h1E);              // caps with shift turns upper case lower
      send_scan(8'h02);              // non-letter unaffected by caps
      send_scan(SC_LSHIFT_BREAK);
      send_scan(SC_CAPS_MAKE | 8'h80); // caps release is ignored
      send_scan(SC_RSHIFT_MAKE);
      send_scan(8'h00);
      send_scan(SC_RSHIFT_BREAK);
      send_scan(SC_LCTRL_MAKE);
      send_scan(SC_LALT_MAKE);
      send_scan(SC_LCTRL_BREAK);
      send_scan(SC_LALT_BREAK);
      send_scan(SC_CAPS_MAKE);
      send_pop();

      // random mix with moderate draining
      repeat (220) send_random_item(25);

      // load a small key block, then type on it without popping so the
      // queue fills and characters start to drop
      for (int i = 0; i < 10; i++) begin
         send_table_write(MODE_WR_NORMAL, 7'(7'h10 + i), pick_char());
         send_table_write(MODE_WR_SHIFTED, 7'(7'h10 + i), pick_char());
      end
      repeat (290) begin
         if ($urandom_range(0, 9) == 0)
            send_scan(modifier_codes[$urandom_range(0, 8)]);
         else
            send_scan(8'(8'h10 + $urandom_range(0, 9)));
      end

      // drain-heavy mix
      repeat (120) send_random_item(70);

      req_valid <= 1'b0;
      while (responses_owed != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
